// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W        = 24;
  localparam int SIDX_W         = 10;
  localparam int LOOK_W         = 23;
  localparam int FIDX_W         = 10;
  localparam int SCNT_W         = 11;
  localparam int LIM_W          = 2 * LOOK_W;
  localparam int DIST_W         = 2 * COORD_W + 1;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_APPEND    = 2'd1,
    CMD_NEAREST   = 2'd2,
    CMD_LOOKAHEAD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_WALK,
    S_RESP
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] car_x;
    logic signed [COORD_W-1:0] car_y;
    logic [SIDX_W-1:0]         start_index;
    logic [LOOK_W-1:0]         lookahead_dist;
  } pps_in_t;

  typedef struct packed {
    logic [FIDX_W-1:0] found_index;
    status_t           status;
    logic [SCNT_W-1:0] stored_count;
  } pps_out_t;

  // position of a point within one walk over the ring
  typedef struct packed {
    logic first;
    logic last;
  } walk_tag_t;

endpackage

// ===== hw/rtl/pps_mod.sv =====
module pps_mod import pps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [SIDX_W-1:0]                           dividend,
  input  logic [$clog2(MAX_POINTS+1)-1:0]             divisor,
  output logic                                        done,
  output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rem
);

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(SIDX_W + 1);

  logic [CW-1:0]     rem_r, rem_nxt;
  logic [SIDX_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CW:0]       rem_sh;
  logic [CW:0]       rem_sub;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    rem_sh   = {rem_r, sh_r[SIDX_W-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      sh_nxt  = dividend;
      cnt_nxt = CNT_W'(SIDX_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = (rem_sh >= {1'b0, divisor}) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      sh_nxt  = {sh_r[SIDX_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[IW-1:0];

endmodule

// ===== hw/rtl/pps_dist.sv =====
module pps_dist import pps_pkg::*; #(
  parameter int IW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      flush,
  input  logic                      in_vld,
  input  logic signed [COORD_W-1:0] pt_x,
  input  logic signed [COORD_W-1:0] pt_y,
  input  logic signed [COORD_W-1:0] car_x,
  input  logic signed [COORD_W-1:0] car_y,
  input  logic [IW-1:0]             in_idx,
  input  walk_tag_t                 in_tag,
  output logic                      d_vld,
  output logic [DIST_W-1:0]         d,
  output logic [IW-1:0]             d_idx,
  output walk_tag_t                 d_tag
);

  localparam int DX_W = COORD_W + 1;
  localparam int SQ_W = 2 * COORD_W;

  logic signed [DX_W-1:0] dx, dy;
  logic [DX_W-1:0]        nx, ny;
  logic [COORD_W-1:0]     ax_nxt, ay_nxt;

  logic                   a_vld_r;
  logic [COORD_W-1:0]     ax_r, ay_r;
  logic [IW-1:0]          a_idx_r;
  walk_tag_t              a_tag_r;

  logic                   s_vld_r;
  logic [SQ_W-1:0]        sx_r, sy_r;
  logic [IW-1:0]          s_idx_r;
  walk_tag_t              s_tag_r;

  logic                   d_vld_r;
  logic [DIST_W-1:0]      d_r;
  logic [IW-1:0]          d_idx_r;
  walk_tag_t              d_tag_r;

  always_comb begin
    dx     = DX_W'(pt_x) - DX_W'(car_x);
    dy     = DX_W'(pt_y) - DX_W'(car_y);
    nx     = -dx;
    ny     = -dy;
    ax_nxt = dx[DX_W-1] ? nx[COORD_W-1:0] : dx[COORD_W-1:0];
    ay_nxt = dy[DX_W-1] ? ny[COORD_W-1:0] : dy[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      a_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      s_vld_r <= a_vld_r;
      d_vld_r <= s_vld_r;
    end
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    a_idx_r <= in_idx;
    a_tag_r <= in_tag;
    sx_r    <= ax_r * ax_r;
    sy_r    <= ay_r * ay_r;
    s_idx_r <= a_idx_r;
    s_tag_r <= a_tag_r;
    d_r     <= DIST_W'(sx_r) + DIST_W'(sy_r);
    d_idx_r <= s_idx_r;
    d_tag_r <= s_tag_r;
  end

  assign d_vld = d_vld_r;
  assign d     = d_r;
  assign d_idx = d_idx_r;
  assign d_tag = d_tag_r;

endmodule

// ===== hw/rtl/path_point_search.sv =====
// Path point table with nearest-point and lookahead-point search. Points are
// appended into a single-port table of MAX_POINTS entries; clear and append
// pass from acceptance through S_RESP into the output register. A query
// streams the stored points through the table's one read port, one point
// per cycle, into a three-stage squared-distance pipeline. A lookahead query
// first reduces start_index modulo the count in a bit-serial remainder unit,
// then walks the ring from there and stops at the first qualifying point,
// or returns the farthest point if none qualifies. A query on an empty
// table answers with empty status through S_RESP without a walk. One item
// is processed at a time; the next transaction is taken as soon as the
// previous result is in the output register.
module path_point_search import pps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pps_out_t out_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * COORD_W;

  logic [PW-1:0] mem [MAX_POINTS];

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      look_r, look_nxt;
  logic signed [COORD_W-1:0] car_x_r, car_x_nxt;
  logic signed [COORD_W-1:0] car_y_r, car_y_nxt;
  logic [LIM_W-1:0]          limit_r, limit_nxt;
  logic [IW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]             steps_r, steps_nxt;
  logic [DIST_W-1:0]         best_d_r, best_d_nxt;
  logic [IW-1:0]             best_idx_r, best_idx_nxt;
  logic [IW-1:0]             res_idx_r, res_idx_nxt;
  status_t                   res_st_r, res_st_nxt;
  logic                      out_valid_r, out_valid_nxt;
  pps_out_t                  out_data_r, out_data_nxt;

  logic          in_fire;
  logic          wr_en;
  logic          issue;
  walk_tag_t     issue_tag;
  logic          mod_start;
  logic          mod_done;
  logic [IW-1:0] mod_rem;

  logic          rd_vld_r;
  logic [PW-1:0] rd_data_r;
  logic [IW-1:0] rd_tag_idx_r;
  walk_tag_t     rd_tag_r;

  logic              d_vld;
  logic [DIST_W-1:0] d;
  logic [IW-1:0]     d_idx;
  walk_tag_t         d_tag;
  logic              upd;
  logic              reach;
  logic [IW-1:0]     best_idx_upd;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign wr_en     = in_fire && (in_data.cmd == CMD_APPEND) &&
                     (count_r < CW'(MAX_POINTS));
  assign mod_start = in_fire && (in_data.cmd == CMD_LOOKAHEAD) && (count_r != '0);
  assign issue     = (state_r == S_WALK) && (steps_r != count_r);
  assign issue_tag = '{first: (steps_r == '0), last: ((steps_r + CW'(1)) == count_r)};

  pps_mod #(.MAX_POINTS(MAX_POINTS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.start_index),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IW-1:0]] <= {in_data.point_x, in_data.point_y};
    end
    if (issue) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
    rd_tag_idx_r <= rd_idx_r;
    rd_tag_r     <= issue_tag;
  end

  pps_dist #(.IW(IW)) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .flush  (state_r != S_WALK),
    .in_vld (rd_vld_r),
    .pt_x   (rd_data_r[PW-1:COORD_W]),
    .pt_y   (rd_data_r[COORD_W-1:0]),
    .car_x  (car_x_r),
    .car_y  (car_y_r),
    .in_idx (rd_tag_idx_r),
    .in_tag (rd_tag_r),
    .d_vld  (d_vld),
    .d      (d),
    .d_idx  (d_idx),
    .d_tag  (d_tag)
  );

  always_comb begin
    upd          = d_tag.first || (look_r ? (best_d_r < d) : (d < best_d_r));
    reach        = look_r && (d >= DIST_W'(limit_r));
    best_idx_upd = upd ? d_idx : best_idx_r;

    state_nxt     = state_r;
    count_nxt     = count_r;
    look_nxt      = look_r;
    car_x_nxt     = car_x_r;
    car_y_nxt     = car_y_r;
    limit_nxt     = limit_r;
    rd_idx_nxt    = rd_idx_r;
    steps_nxt     = steps_r;
    best_d_nxt    = best_d_r;
    best_idx_nxt  = best_idx_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          look_nxt    = (in_data.cmd == CMD_LOOKAHEAD);
          car_x_nxt   = in_data.car_x;
          car_y_nxt   = in_data.car_y;
          limit_nxt   = in_data.lookahead_dist * in_data.lookahead_dist;
          rd_idx_nxt  = '0;
          steps_nxt   = '0;
          res_idx_nxt = '0;
          res_st_nxt  = STAT_OK;
          state_nxt   = S_RESP;
          case (in_data.cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CW'(1);
              end else begin
                res_st_nxt = STAT_FULL;
              end
            end
            CMD_NEAREST: begin
              if (count_r == '0) begin
                res_st_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
            CMD_LOOKAHEAD: begin
              if (count_r == '0) begin
                res_st_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_MOD;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          rd_idx_nxt = mod_rem;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (issue) begin
          steps_nxt  = steps_r + CW'(1);
          rd_idx_nxt = ((CW'(rd_idx_r) + CW'(1)) == count_r) ? '0 : rd_idx_r + IW'(1);
        end
        if (d_vld) begin
          if (upd) begin
            best_d_nxt   = d;
            best_idx_nxt = d_idx;
          end
          if (reach) begin
            res_idx_nxt = d_idx;
            state_nxt   = S_RESP;
          end else if (d_tag.last) begin
            res_idx_nxt = best_idx_upd;
            state_nxt   = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.found_index  = FIDX_W'(res_idx_r);
          out_data_nxt.status       = res_st_r;
          out_data_nxt.stored_count = SCNT_W'(count_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    look_r     <= look_nxt;
    car_x_r    <= car_x_nxt;
    car_y_r    <= car_y_nxt;
    limit_r    <= limit_nxt;
    rd_idx_r   <= rd_idx_nxt;
    steps_r    <= steps_nxt;
    best_d_r   <= best_d_nxt;
    best_idx_r <= best_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/pps_chk.sv =====
module pps_chk import pps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input pps_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input pps_out_t out_data
);

  localparam logic [SCNT_W-1:0] FULL_CNT = SCNT_W'(MAX_POINTS);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // errors carry index zero
  a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |-> (out_data.found_index == '0))
    else $error("error transaction with nonzero index");

  // full only reported at capacity, empty only on an empty table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_FULL) |-> (out_data.stored_count == FULL_CNT))
    else $error("full status below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_EMPTY) |-> (out_data.stored_count == '0))
    else $error("empty status with stored points");

  // a found point lies inside the table
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_OK) && (out_data.found_index != '0)
    |-> (SCNT_W'(out_data.found_index) < out_data.stored_count))
    else $error("found index beyond stored count");

endmodule

bind path_point_search pps_chk #(.MAX_POINTS(MAX_POINTS)) u_pps_chk (.*);
